>>> rtl/core/wavhd_pkg.sv
`timescale 1ns / 1ps
package wavhd_pkg;

  localparam logic [31:0] RiffTag = 32'h5249_4646;
  localparam logic [31:0] WaveTag = 32'h5741_5645;
  localparam logic [31:0] DataTag = 32'h6461_7461;
  localparam logic [23:0] FmtTag  = 24'h666D74;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned FmtBytes   = 16;

  typedef enum logic [2:0] {
    StatusOk        = 3'd0,
    StatusContainer = 3'd1,
    StatusNotPcm    = 3'd2,
    StatusChannels  = 3'd3,
    StatusRates     = 3'd4,
    StatusDepth     = 3'd5,
    StatusTruncated = 3'd6
  } wavhd_status_e;

  // one classified byte handed from the front to the back
  typedef struct packed {
    logic [7:0]                data_byte;
    logic                      payload;
    logic                      last;
    logic                      short_file;
    logic                      container_ok;
    logic                      fmt_full;
    logic                      size_full;
    logic [FmtBytes-1:0][7:0]  fmt;
    logic [31:0]               size;
  } wavhd_item_t;

  typedef struct packed {
    logic [7:0]    byte_out;
    logic          is_payload;
    logic          is_final;
    wavhd_status_e status_code;
    logic [15:0]   channel_count;
    logic [31:0]   sample_rate;
    logic [31:0]   byte_rate;
    logic [15:0]   block_align;
    logic [15:0]   sample_bits;
    logic [31:0]   payload_size;
  } wavhd_res_t;

  // byte idx of a four character tag, first character at idx 0
  function automatic logic [7:0] tag_byte(input logic [31:0] tag, input logic [1:0] idx);
    logic [7:0] res;
    case (idx)
      2'd0:    res = tag[31:24];
      2'd1:    res = tag[23:16];
      2'd2:    res = tag[15:8];
      default: res = tag[7:0];
    endcase
    return res;
  endfunction

endpackage

>>> rtl/core/wav_header_deframer_unit.sv
`timescale 1ns / 1ps
// byte-serial wav (riff/pcm) header deframer
// input: one file byte per request on data_byte_i, last_byte_i high on the
//   final byte; a request is taken when push is high and full is low
// output: one result per byte, oldest on the ports while empty is low,
//   taken when pop is high; byte passed through plus payload mark, and on
//   the final byte the status code and captured format fields
// path: an ordinary byte reaches the result ports via the queue and the
//   output register; a final byte also via two registered multiply steps
// throughput: one byte per cycle while full is low; a final byte holds
//   the back end while the 2-entry queue takes up to two bytes behind it
// reset: all parse state back to the start of a file, queue and output
//   slot empty; after every final byte the parser also starts a new file
// stall: when pop stays low the output slot and queue fill, then full rises
module wav_header_deframer_unit
  import wavhd_pkg::*;
#(
  parameter int unsigned POSITION_BITS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic [7:0]         data_byte_i,
  input  logic               last_byte_i,
  output logic               empty,
  input  logic               pop,
  output logic [7:0]         byte_out_o,
  output logic               is_payload_o,
  output logic               is_final_o,
  output logic [2:0]         status_code_o,
  output logic signed [15:0] channel_count_o,
  output logic [31:0]        sample_rate_out_o,
  output logic signed [31:0] byte_rate_out_o,
  output logic signed [15:0] block_align_out_o,
  output logic signed [15:0] sample_bits_out_o,
  output logic signed [31:0] payload_size_out_o
);

  wavhd_item_t front_item, head_item;
  wavhd_res_t  res;
  logic        take, head_valid, head_rd, res_valid;

  assign take = push & ~full;

  wavhd_front #(
    .POSITION_BITS(POSITION_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .take_i     (take),
    .data_byte_i(data_byte_i),
    .last_byte_i(last_byte_i),
    .item_o     (front_item)
  );

  wavhd_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (push),
    .wr_item_i(front_item),
    .full_o   (full),
    .rd_i     (head_rd),
    .valid_o  (head_valid),
    .rd_item_o(head_item)
  );

  wavhd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_valid_i(head_valid),
    .item_i      (head_item),
    .item_rd_o   (head_rd),
    .pop_i       (pop),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  assign empty              = ~res_valid;
  assign byte_out_o         = res.byte_out;
  assign is_payload_o       = res.is_payload;
  assign is_final_o         = res.is_final;
  assign status_code_o      = res.status_code;
  assign channel_count_o    = res.channel_count;
  assign sample_rate_out_o  = res.sample_rate;
  assign byte_rate_out_o    = res.byte_rate;
  assign block_align_out_o  = res.block_align;
  assign sample_bits_out_o  = res.sample_bits;
  assign payload_size_out_o = res.payload_size;

endmodule

>>> rtl/core/wavhd_fifo.sv
`timescale 1ns / 1ps
module wavhd_fifo
  import wavhd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        wr_i,
  input  wavhd_item_t wr_item_i,
  output logic        full_o,
  input  logic        rd_i,
  output logic        valid_o,
  output wavhd_item_t rd_item_o
);

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  wavhd_item_t         entry_q [QueueDepth];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     count_q, count_d;
  logic                do_wr, do_rd;

  assign full_o    = (count_q == CntW'(QueueDepth));
  assign valid_o   = (count_q != '0);
  assign rd_item_o = entry_q[rd_ptr_q];
  assign do_wr     = wr_i & ~full_o;
  assign do_rd     = rd_i & valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_wr && !do_rd) begin
      count_d = count_q + CntW'(1);
    end else if (do_rd && !do_wr) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      entry_q[wr_ptr_q] <= wr_item_i;
    end
  end

endmodule

>>> rtl/core/wavhd_front.sv
`timescale 1ns / 1ps
module wavhd_front
  import wavhd_pkg::*;
#(
  parameter int unsigned POSITION_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        take_i,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  output wavhd_item_t item_o
);

  localparam int unsigned P  = POSITION_BITS;
  localparam int unsigned PX = POSITION_BITS + 1;

  logic [P-1:0]              pos_q;
  logic [31:0]               recent_q, recent_d;
  logic                      riff_ok_q, riff_ok_d;
  logic                      wave_ok_q, wave_ok_d;
  logic                      fmt_found_q, fmt_found_d;
  logic [P-1:0]              fmt_pos_q, fmt_pos_d;
  logic                      data_found_q, data_found_d;
  logic [P-1:0]              data_pos_q, data_pos_d;
  logic [4:0]                fmt_seen_q, fmt_seen_d;
  logic [FmtBytes-1:0][7:0]  fmt_q, fmt_d;
  logic [2:0]                size_seen_q, size_seen_d;
  logic [31:0]               size_q, size_d;

  logic [PX-1:0] pos_x;
  logic [PX-1:0] pay_start, pay_off;
  logic [PX-1:0] fmt_start, fmt_off;
  logic [PX-1:0] size_start, size_off;
  logic          payload, fmt_wr, size_wr;

  always_comb begin
    pos_x      = {1'b0, pos_q};
    pay_start  = {1'b0, data_pos_q} + PX'(8);
    pay_off    = pos_x - pay_start;
    fmt_start  = {1'b0, fmt_pos_q} + PX'(8);
    fmt_off    = pos_x - fmt_start;
    size_start = {1'b0, data_pos_q} + PX'(4);
    size_off   = pos_x - size_start;

    riff_ok_d = riff_ok_q;
    if (pos_x < PX'(4) && data_byte_i != tag_byte(RiffTag, pos_q[1:0])) begin
      riff_ok_d = 1'b0;
    end
    wave_ok_d = wave_ok_q;
    if (pos_x >= PX'(8) && pos_x < PX'(12) && data_byte_i != tag_byte(WaveTag, pos_q[1:0])) begin
      wave_ok_d = 1'b0;
    end

    // marking uses the size as it stood before this byte
    payload = data_found_q && (size_seen_q >= 3'd4) && !size_q[31] &&
              (pos_x >= pay_start) && (34'(pay_off) < 34'(size_q));

    fmt_wr     = fmt_found_q && (pos_x >= fmt_start) && (fmt_off < PX'(FmtBytes));
    fmt_d      = fmt_q;
    fmt_seen_d = fmt_seen_q;
    if (fmt_wr) begin
      fmt_d[fmt_off[3:0]] = data_byte_i;
      fmt_seen_d          = {1'b0, fmt_off[3:0]} + 5'd1;
    end

    size_wr     = data_found_q && (pos_x >= size_start) && (size_off < PX'(4));
    size_d      = size_q;
    size_seen_d = size_seen_q;
    if (size_wr) begin
      size_d[8*size_off[1:0] +: 8] = data_byte_i;
      size_seen_d                  = {1'b0, size_off[1:0]} + 3'd1;
    end

    recent_d     = {recent_q[23:0], data_byte_i};
    fmt_found_d  = fmt_found_q;
    fmt_pos_d    = fmt_pos_q;
    data_found_d = data_found_q;
    data_pos_d   = data_pos_q;
    // a tag completed by the final byte does not count
    if (!last_byte_i) begin
      if (!fmt_found_q && pos_x >= PX'(2) && recent_d[23:0] == FmtTag) begin
        fmt_found_d = 1'b1;
        fmt_pos_d   = pos_q - P'(2);
      end
      if (!data_found_q && pos_x >= PX'(3) && recent_d == DataTag) begin
        data_found_d = 1'b1;
        data_pos_d   = pos_q - P'(3);
      end
    end

    item_o.data_byte    = data_byte_i;
    item_o.payload      = payload;
    item_o.last         = last_byte_i;
    item_o.short_file   = (pos_x < PX'(11));
    item_o.container_ok = riff_ok_d & wave_ok_d & fmt_found_q & data_found_q;
    item_o.fmt_full     = (fmt_seen_d >= 5'd16);
    item_o.size_full    = (size_seen_d >= 3'd4);
    item_o.fmt          = fmt_d;
    item_o.size         = size_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= '0;
      recent_q     <= '0;
      riff_ok_q    <= 1'b1;
      wave_ok_q    <= 1'b1;
      fmt_found_q  <= 1'b0;
      fmt_pos_q    <= '0;
      data_found_q <= 1'b0;
      data_pos_q   <= '0;
      fmt_seen_q   <= '0;
      fmt_q        <= '0;
      size_seen_q  <= '0;
      size_q       <= '0;
    end else if (take_i) begin
      if (last_byte_i) begin
        // the next byte opens a new file
        pos_q        <= '0;
        recent_q     <= '0;
        riff_ok_q    <= 1'b1;
        wave_ok_q    <= 1'b1;
        fmt_found_q  <= 1'b0;
        fmt_pos_q    <= '0;
        data_found_q <= 1'b0;
        data_pos_q   <= '0;
        fmt_seen_q   <= '0;
        fmt_q        <= '0;
        size_seen_q  <= '0;
        size_q       <= '0;
      end else begin
        if (pos_q != '1) begin
          pos_q <= pos_q + P'(1);
        end
        recent_q     <= recent_d;
        riff_ok_q    <= riff_ok_d;
        wave_ok_q    <= wave_ok_d;
        fmt_found_q  <= fmt_found_d;
        fmt_pos_q    <= fmt_pos_d;
        data_found_q <= data_found_d;
        data_pos_q   <= data_pos_d;
        fmt_seen_q   <= fmt_seen_d;
        fmt_q        <= fmt_d;
        size_seen_q  <= size_seen_d;
        size_q       <= size_d;
      end
    end
  end

endmodule

>>> rtl/core/wavhd_back.sv
`timescale 1ns / 1ps
module wavhd_back
  import wavhd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        item_valid_i,
  input  wavhd_item_t item_i,
  output logic        item_rd_o,
  input  logic        pop_i,
  output logic        res_valid_o,
  output wavhd_res_t  res_o
);

  localparam logic [1:0] SIdle = 2'd0;
  localparam logic [1:0] SMul1 = 2'd1;
  localparam logic [1:0] SMul2 = 2'd2;
  localparam logic [1:0] SFin  = 2'd3;

  logic [1:0]   state_q, state_d;
  wavhd_item_t  work_q;
  logic [31:0]  prod1_q, prod_q;
  logic         res_valid_q, res_valid_d;
  wavhd_res_t   res_q, res_d;
  logic         out_free;

  logic [15:0]  fmt_tag, chans, ba, bits;
  logic [31:0]  rate, bps;
  logic [63:0]  mul1, mul2;
  logic [16:0]  bits_adj, quot, exp_ba;
  logic         ch_ok, rate_ok, depth_ok;
  wavhd_status_e status;

  assign fmt_tag = {work_q.fmt[1], work_q.fmt[0]};
  assign chans   = {work_q.fmt[3], work_q.fmt[2]};
  assign rate    = {work_q.fmt[7], work_q.fmt[6], work_q.fmt[5], work_q.fmt[4]};
  assign bps     = {work_q.fmt[11], work_q.fmt[10], work_q.fmt[9], work_q.fmt[8]};
  assign ba      = {work_q.fmt[13], work_q.fmt[12]};
  assign bits    = {work_q.fmt[15], work_q.fmt[14]};

  // wrapping product taken in two registered steps
  assign mul1 = {{16{chans[15]}}, chans} * rate;
  assign mul2 = prod1_q * {{16{bits[15]}}, bits};

  always_comb begin
    // signed divide by eight rounding toward zero
    bits_adj = {bits[15], bits} + (bits[15] ? 17'd7 : 17'd0);
    quot     = {{3{bits_adj[16]}}, bits_adj[16:3]};
    exp_ba   = (chans == 16'd1) ? quot : {quot[15:0], 1'b0};
    ch_ok    = (chans == 16'd1) || (chans == 16'd2);
    rate_ok  = (bps == {3'b000, prod_q[31:3]}) && ({ba[15], ba} == exp_ba);
    depth_ok = (bits == 16'd8) || (bits == 16'd16) || (bits == 16'd24);

    if (work_q.short_file) begin
      status = StatusTruncated;
    end else if (!work_q.container_ok) begin
      status = StatusContainer;
    end else if (!work_q.fmt_full) begin
      status = StatusTruncated;
    end else if (fmt_tag != 16'd1) begin
      status = StatusNotPcm;
    end else if (!ch_ok) begin
      status = StatusChannels;
    end else if (!rate_ok) begin
      status = StatusRates;
    end else if (!depth_ok) begin
      status = StatusDepth;
    end else if (!work_q.size_full) begin
      status = StatusTruncated;
    end else begin
      status = StatusOk;
    end
  end

  always_comb begin
    out_free    = ~res_valid_q | pop_i;
    state_d     = state_q;
    item_rd_o   = 1'b0;
    res_valid_d = res_valid_q & ~pop_i;
    res_d       = res_q;
    case (state_q)
      SIdle: begin
        if (item_valid_i) begin
          if (!item_i.last) begin
            if (out_free) begin
              item_rd_o         = 1'b1;
              res_valid_d       = 1'b1;
              res_d             = '0;
              res_d.byte_out    = item_i.data_byte;
              res_d.is_payload  = item_i.payload;
            end
          end else begin
            item_rd_o = 1'b1;
            state_d   = SMul1;
          end
        end
      end
      SMul1: state_d = SMul2;
      SMul2: state_d = SFin;
      SFin: begin
        if (out_free) begin
          res_valid_d         = 1'b1;
          res_d.byte_out      = work_q.data_byte;
          res_d.is_payload    = work_q.payload;
          res_d.is_final      = 1'b1;
          res_d.status_code   = status;
          res_d.channel_count = chans;
          res_d.sample_rate   = rate;
          res_d.byte_rate     = bps;
          res_d.block_align   = ba;
          res_d.sample_bits   = bits;
          res_d.payload_size  = work_q.size;
          state_d             = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (state_q == SIdle && item_rd_o) begin
      work_q <= item_i;
    end
    if (state_q == SMul1) begin
      prod1_q <= mul1[31:0];
    end
    if (state_q == SMul2) begin
      prod_q <= mul2[31:0];
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

>>> tb/wav_header_deframer_unit_test.sv
`timescale 1ns / 1ps
module wav_header_deframer_unit_test;
  import wavhd_pkg::*;

  localparam int unsigned PosBits = 32;
  localparam longint unsigned PosMax = (64'd1 << PosBits) - 64'd1;
  localparam int unsigned StreamBytes = 750;

  typedef struct {
    logic [7:0] value;
    logic       last;
  } file_byte_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic [7:0] data_byte_i = 8'h00;
  logic last_byte_i = 1'b0;
  logic pop = 1'b0;
  logic full;
  logic empty;
  logic [7:0] byte_out_o;
  logic is_payload_o;
  logic is_final_o;
  logic [2:0] status_code_o;
  logic signed [15:0] channel_count_o;
  logic [31:0] sample_rate_out_o;
  logic signed [31:0] byte_rate_out_o;
  logic signed [15:0] block_align_out_o;
  logic signed [15:0] sample_bits_out_o;
  logic signed [31:0] payload_size_out_o;

  wav_header_deframer_unit #(
    .POSITION_BITS(PosBits)
  ) u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .push              (push),
    .full              (full),
    .data_byte_i       (data_byte_i),
    .last_byte_i       (last_byte_i),
    .empty             (empty),
    .pop               (pop),
    .byte_out_o        (byte_out_o),
    .is_payload_o      (is_payload_o),
    .is_final_o        (is_final_o),
    .status_code_o     (status_code_o),
    .channel_count_o   (channel_count_o),
    .sample_rate_out_o (sample_rate_out_o),
    .byte_rate_out_o   (byte_rate_out_o),
    .block_align_out_o (block_align_out_o),
    .sample_bits_out_o (sample_bits_out_o),
    .payload_size_out_o(payload_size_out_o)
  );

  // stimulus and scoreboard bookkeeping
  logic [7:0] file_q[$];
  file_byte_t pending_bytes[$];
  wavhd_res_t parsed_bytes[$];
  int bytes_taken = 0;
  int results_taken = 0;
  int byte_idx = 0;
  int pops_seen = 0;
  int push_gap = 0;
  int push_calm = 0;
  int pop_stall = 0;
  int pop_calm = 0;
  int mismatches = 0;
  int files_sent = 0;
  int payload_marks = 0;
  int status_hits[8];

  // parser state mirrored by the predictor
  longint unsigned file_pos;
  longint unsigned fmt_at;
  longint unsigned data_at;
  logic [31:0] tail_bytes;
  logic [31:0] chunk_size;
  logic riff_good;
  logic wave_good;
  logic fmt_seen;
  logic data_seen;
  int unsigned fmt_count;
  int unsigned size_count;
  logic [15:0][7:0] fmt_raw;

  function automatic void clear_parser();
    file_pos = 0;
    fmt_at = 0;
    data_at = 0;
    tail_bytes = '0;
    chunk_size = '0;
    riff_good = 1'b1;
    wave_good = 1'b1;
    fmt_seen = 1'b0;
    data_seen = 1'b0;
    fmt_count = 0;
    size_count = 0;
    fmt_raw = '0;
  endfunction

  function automatic wavhd_res_t deframe_byte(input logic [7:0] b, input logic last);
    wavhd_res_t res;
    longint unsigned p;
    int unsigned k;
    logic signed [15:0] ch16;
    logic signed [15:0] bits16;
    logic signed [15:0] align16;
    int chs;
    int bits_s;
    int align_s;
    logic [31:0] prod;
    p = file_pos;
    res = '0;
    if (p < 4 && b != RiffTag[8 * (3 - int'(p)) +: 8]) riff_good = 1'b0;
    if (p >= 8 && p < 12 && b != WaveTag[8 * (11 - int'(p)) +: 8]) wave_good = 1'b0;
    // payload mark uses the size as it stood before this byte
    if (data_seen && size_count >= 4 && !chunk_size[31] && p >= data_at + 8 &&
        p - (data_at + 8) < {32'd0, chunk_size}) begin
      res.is_payload = 1'b1;
    end
    if (fmt_seen && p >= fmt_at + 8 && p - (fmt_at + 8) < 16) begin
      k = int'(p - (fmt_at + 8));
      fmt_raw[k] = b;
      fmt_count = k + 1;
    end
    if (data_seen && p >= data_at + 4 && p - (data_at + 4) < 4) begin
      k = int'(p - (data_at + 4));
      chunk_size[8 * k +: 8] = b;
      size_count = k + 1;
    end
    tail_bytes = {tail_bytes[23:0], b};
    if (!last) begin
      if (!fmt_seen && p >= 2 && tail_bytes[23:0] == FmtTag) begin
        fmt_seen = 1'b1;
        fmt_at = p - 2;
      end
      if (!data_seen && p >= 3 && tail_bytes == DataTag) begin
        data_seen = 1'b1;
        data_at = p - 3;
      end
    end
    res.byte_out = b;
    res.is_final = last;
    if (last) begin
      ch16 = fmt_raw[3:2];
      align16 = fmt_raw[13:12];
      bits16 = fmt_raw[15:14];
      chs = ch16;
      align_s = align16;
      bits_s = bits16;
      if (p < 11) begin
        res.status_code = StatusTruncated;
      end else if (!riff_good || !wave_good || !fmt_seen || !data_seen) begin
        res.status_code = StatusContainer;
      end else if (fmt_count < 16) begin
        res.status_code = StatusTruncated;
      end else if (fmt_raw[1:0] != 16'd1) begin
        res.status_code = StatusNotPcm;
      end else if (chs < 1 || chs > 2) begin
        res.status_code = StatusChannels;
      end else begin
        prod = 32'(chs) * fmt_raw[7:4] * 32'(bits_s);
        if (fmt_raw[11:8] != prod / 32'd8 || align_s != chs * (bits_s / 8)) begin
          res.status_code = StatusRates;
        end else if (bits_s != 8 && bits_s != 16 && bits_s != 24) begin
          res.status_code = StatusDepth;
        end else if (size_count < 4) begin
          res.status_code = StatusTruncated;
        end else begin
          res.status_code = StatusOk;
        end
      end
      res.channel_count = fmt_raw[3:2];
      res.sample_rate = fmt_raw[7:4];
      res.byte_rate = fmt_raw[11:8];
      res.block_align = fmt_raw[13:12];
      res.sample_bits = fmt_raw[15:14];
      res.payload_size = chunk_size;
      clear_parser();
    end else if (file_pos < PosMax) begin
      file_pos = p + 1;
    end
    return res;
  endfunction

  task automatic check_field(input string what, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("result %0d %s: expected %0h, got %0h", results_taken, what, want, got);
      end
    end
  endtask

  // quiet stretches with no waiting, otherwise a random wait per request
  function automatic int pick_wait(inout int calm_left);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm_left = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, 7);
  endfunction

  task automatic add_byte(input logic [7:0] v);
    file_q.insert(file_q.size(), v);
  endtask

  task automatic put16(input logic [15:0] v);
    add_byte(v[7:0]);
    add_byte(v[15:8]);
  endtask

  task automatic put32(input logic [31:0] v);
    put16(v[15:0]);
    put16(v[31:16]);
  endtask

  task automatic put_tag(input logic [31:0] tag);
    for (int i = 3; i >= 0; i--) add_byte(tag[8 * i +: 8]);
  endtask

  task automatic flush_file(input int keep);
    file_byte_t fb;
    for (int i = 0; i < keep; i++) begin
      fb.value = file_q[i];
      fb.last = (i == keep - 1);
      pending_bytes.insert(pending_bytes.size(), fb);
    end
    file_q.delete();
    files_sent++;
  endtask

  task automatic put_data_chunk(input logic [31:0] size);
    int n;
    put_tag(DataTag);
    put32(size);
    n = (size > 32'd10) ? $urandom_range(0, 8) : int'(size);
    repeat (n) add_byte(8'($urandom));
  endtask

  // well-formed and flawed files, each with at most one targeted defect
  task automatic build_wav_file();
    int flavour;
    int defect;
    int n;
    int keep;
    int chs;
    int bits_s;
    logic [15:0] fmt_code;
    logic [15:0] chans;
    logic [15:0] depth;
    logic [15:0] align;
    logic [31:0] rate;
    logic [31:0] bytes_sec;
    logic [31:0] size;
    logic [31:0] riff_id;
    logic [31:0] wave_id;
    bit with_fmt;
    bit with_data;
    bit data_first;
    flavour = $urandom_range(0, 11);
    defect = $urandom_range(0, 3);
    if (flavour == 11) begin
      n = $urandom_range(1, 40);
      repeat (n) add_byte(8'($urandom));
      flush_file(n);
      return;
    end
    riff_id = RiffTag;
    wave_id = WaveTag;
    if (flavour == 5 && defect == 0) riff_id = RiffTag ^ (32'd1 << $urandom_range(0, 31));
    if (flavour == 5 && defect == 1) wave_id = WaveTag ^ (32'd1 << $urandom_range(0, 31));
    with_fmt = !(flavour == 5 && defect == 2);
    with_data = !(flavour == 5 && defect == 3);
    data_first = ($urandom_range(0, 9) == 0);
    fmt_code = 16'd1;
    if (flavour == 6) begin
      fmt_code = 16'($urandom);
      if (fmt_code == 16'd1) fmt_code = 16'd0;
    end
    chans = 16'($urandom_range(1, 2));
    if (flavour == 7) begin
      case ($urandom_range(0, 3))
        0: chans = 16'h0000;
        1: chans = 16'hFFFF;
        2: chans = 16'd3;
        default: chans = 16'($urandom);
      endcase
    end
    depth = 16'(8 * $urandom_range(1, 3));
    if (flavour == 9) begin
      case ($urandom_range(0, 5))
        0: depth = 16'd0;
        1: depth = 16'd12;
        2: depth = 16'd32;
        3: depth = 16'hFFF8;
        4: depth = 16'hFFF4;
        default: depth = 16'($urandom);
      endcase
    end
    case ($urandom_range(0, 4))
      0: rate = 32'd8000;
      1: rate = 32'd44100;
      2: rate = 32'd48000;
      3: rate = 32'd96000;
      default: rate = $urandom;
    endcase
    chs = $signed(chans);
    bits_s = $signed(depth);
    bytes_sec = (32'(chs) * rate * 32'(bits_s)) / 32'd8;
    align = 16'(chs * (bits_s / 8));
    if (flavour == 8) begin
      if (defect < 2) bytes_sec ^= 32'd1 << $urandom_range(0, 31);
      else align ^= 16'd1 << $urandom_range(0, 15);
    end
    case ($urandom_range(0, 9))
      0: size = 32'd0;
      1: size = 32'h8000_0000 | $urandom;
      2: size = $urandom_range(32'd64, 32'h7FFF_FFFF);
      default: size = $urandom_range(1, 10);
    endcase
    put_tag(riff_id);
    put32($urandom);
    put_tag(wave_id);
    if ($urandom_range(0, 3) == 0) begin
      put_tag($urandom_range(0, 1) ? 32'h4C49_5354 : $urandom);
      n = $urandom_range(0, 6);
      put32(32'(n));
      repeat (n) add_byte(8'($urandom));
    end
    if (data_first && with_data) put_data_chunk(size);
    if (with_fmt) begin
      put_tag({FmtTag, 8'h20});
      put32(32'd16);
      put16(fmt_code);
      put16(chans);
      put32(rate);
      put32(bytes_sec);
      put16(align);
      put16(depth);
    end
    if (!data_first && with_data) put_data_chunk(size);
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 4)) add_byte(8'($urandom));
    end
    keep = file_q.size();
    if (flavour == 10) keep = $urandom_range(1, keep - 1);
    flush_file(keep);
  endtask

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      push <= 1'b0;
    end else begin
      if (push && bytes_taken != byte_idx) begin
        byte_idx = bytes_taken;
        push_gap = pick_wait(push_calm);
      end
      if (push_gap > 0) begin
        push_gap--;
        push <= 1'b0;
      end else if (byte_idx < pending_bytes.size()) begin
        push <= 1'b1;
        data_byte_i <= pending_bytes[byte_idx].value;
        last_byte_i <= pending_bytes[byte_idx].last;
      end else begin
        push <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && results_taken != pops_seen) begin
        pops_seen = results_taken;
        pop_stall = pick_wait(pop_calm);
      end
      if (pop_stall > 0) begin
        pop_stall--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : scoreboard
    wavhd_res_t want;
    if (rst_ni && pop && !empty) begin
      results_taken++;
      if (parsed_bytes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("result %0d arrived with nothing outstanding (byte %0h)", results_taken,
                   byte_out_o);
        end
      end else begin
        want = parsed_bytes.pop_front();
        check_field("byte_out", want.byte_out, byte_out_o);
        check_field("is_payload", want.is_payload, is_payload_o);
        check_field("is_final", want.is_final, is_final_o);
        check_field("status_code", want.status_code, status_code_o);
        check_field("channel_count", {16'd0, want.channel_count}, {16'd0, channel_count_o});
        check_field("sample_rate", want.sample_rate, sample_rate_out_o);
        check_field("byte_rate", want.byte_rate, byte_rate_out_o);
        check_field("block_align", {16'd0, want.block_align}, {16'd0, block_align_out_o});
        check_field("sample_bits", {16'd0, want.sample_bits}, {16'd0, sample_bits_out_o});
        check_field("payload_size", want.payload_size, payload_size_out_o);
        if (want.is_payload) payload_marks++;
        if (want.is_final) status_hits[int'(want.status_code)]++;
      end
    end
    if (rst_ni && push && !full) begin
      parsed_bytes.insert(parsed_bytes.size(), deframe_byte(data_byte_i, last_byte_i));
      bytes_taken++;
    end
  end

  initial begin
    clear_parser();
    foreach (status_hits[i]) status_hits[i] = 0;
    // one-byte file at the top of the byte range
    add_byte(8'hFF);
    flush_file(1);
    // the data tag ends on the final byte, so the container check must fail
    put_tag(RiffTag);
    put32(32'hFF00_FF00);
    put_tag(WaveTag);
    add_byte(FmtTag[23:16]);
    add_byte(FmtTag[15:8]);
    add_byte(FmtTag[7:0]);
    put_tag(DataTag);
    flush_file(file_q.size());
    while (pending_bytes.size() < StreamBytes) build_wav_file();

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (bytes_taken < pending_bytes.size() || parsed_bytes.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    $display("parsed %0d files in %0d bytes, %0d payload bytes marked", files_sent,
             bytes_taken, payload_marks);
    $display("status: ok %0d hdr %0d fmt %0d chan %0d rate %0d depth %0d short %0d",
             status_hits[0], status_hits[1], status_hits[2], status_hits[3], status_hits[4],
             status_hits[5], status_hits[6]);
    if (mismatches == 0 && parsed_bytes.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timed out with %0d of %0d bytes taken", bytes_taken, pending_bytes.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
